### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the loopback serial register block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SLF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SLF_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define SLF_ASSERT(label, clk, rst_n, prop, msg)

`define SLF_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)

`endif

`endif

### rtl/core/slf_pkg.sv
// Types and constants of the loopback serial register block.
package slf_pkg;

  localparam logic [4:0] RegVerid = 5'd0;
  localparam logic [4:0] RegParam = 5'd1;
  localparam logic [4:0] RegCr    = 5'd2;
  localparam logic [4:0] RegSr    = 5'd3;
  localparam logic [4:0] RegIer   = 5'd4;
  localparam logic [4:0] RegDer   = 5'd5;
  localparam logic [4:0] RegCfgr0 = 5'd6;
  localparam logic [4:0] RegCfgr1 = 5'd7;
  localparam logic [4:0] RegDmr0  = 5'd8;
  localparam logic [4:0] RegDmr1  = 5'd9;
  localparam logic [4:0] RegCcr   = 5'd10;
  localparam logic [4:0] RegCcr1  = 5'd11;
  localparam logic [4:0] RegFcr   = 5'd12;
  localparam logic [4:0] RegFsr   = 5'd13;
  localparam logic [4:0] RegTcr   = 5'd14;
  localparam logic [4:0] RegTdr   = 5'd15;
  localparam logic [4:0] RegRsr   = 5'd16;
  localparam logic [4:0] RegRdr   = 5'd17;
  localparam logic [4:0] RegRdror = 5'd18;

  localparam logic [31:0] VersionId   = 32'h0200_0004;
  localparam logic [31:0] ParamId     = 32'h0004_0202;
  localparam logic [31:0] TcrReset    = 32'h0000_001F;
  localparam logic [31:0] RsrRxEmpty  = 32'h0000_0002;

  localparam int CrEnBit  = 0;
  localparam int CrRstBit = 1;
  localparam int CrRtfBit = 8;
  localparam int CrRrfBit = 9;

  localparam logic [2:0] FlagWcf = 3'b001;
  localparam logic [2:0] FlagFcf = 3'b010;
  localparam logic [2:0] FlagTcf = 3'b100;

  localparam int NumSetup = 6;

  typedef struct packed {
    logic        op;
    logic [4:0]  reg_sel;
    logic [31:0] write_data;
  } slf_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        bad_offset;
  } slf_out_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } slf_fifo_ctrl_t;

endpackage

### rtl/core/slf_fifo.sv
// Word FIFO with a registered show-ahead head word.
module slf_fifo import slf_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  slf_fifo_ctrl_t               ctrl_i,
  input  logic [31:0]                  push_data_i,
  output logic [31:0]                  head_o,
  output logic [$clog2(Depth+1)-1:0]   level_o,
  output logic [$clog2(Depth+1)-1:0]   level_next_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int LvlW = $clog2(Depth + 1);

  logic [31:0]     mem_q [Depth];
  logic [31:0]     rd_q;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [LvlW-1:0] level_q, level_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    level_d = level_q;
    if (ctrl_i.flush) begin
      head_d  = '0;
      tail_d  = '0;
      level_d = '0;
    end else begin
      if (ctrl_i.push) tail_d = ptr_inc(tail_q);
      if (ctrl_i.pop) head_d = ptr_inc(head_q);
      level_d = level_q + LvlW'(ctrl_i.push) - LvlW'(ctrl_i.pop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      level_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q] <= push_data_i;
    end
    if (ctrl_i.push && (tail_q == head_d)) begin
      rd_q <= push_data_i;
    end else begin
      rd_q <= mem_q[head_d];
    end
  end

  assign head_o       = rd_q;
  assign level_o      = level_q;
  assign level_next_o = level_d;

endmodule

### rtl/core/spi_loopback_fifo_registers_unit.sv
// Top level of the loopback serial controller register block.
//
// Bus side: one register access per word on the in channel (op, reg_sel,
// write_data); one result word per access on the out channel (read_data,
// irq, bad_offset). Both channels use valid/ready.
// The result is registered and is valid in the cycle after the access is taken.
// Throughput: one access per cycle unless the result stalls; state and flags
// update in the same cycle the access is taken, and the result register holds
// the outcome. Writing TDR pushes into the TX FIFO when it has room and, when
// enabled with RX room, moves the oldest TX word into the RX FIFO at once.
// Reading RDR pops RX, RDROR peeks. irq is sampled after the access.
// Reset: all registers clear, TCR comes up as 0x1F, both FIFOs empty, no
// clearing pass. A stalled receiver holds the result; one more access is
// taken only as the result register empties.
`include "assert_macros.svh"

module spi_loopback_fifo_registers_unit import slf_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  slf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output slf_out_t out_data_o
);

  localparam int LvlW = $clog2(FIFO_DEPTH + 1);

  logic [31:0] cr_q, cr_d, ier_q, ier_d, der_q, der_d;
  logic [31:0] fcr_q, fcr_d, tcr_q, tcr_d;
  logic [31:0] setup_q [NumSetup];
  logic [31:0] setup_d [NumSetup];
  logic [2:0]  sticky_q, sticky_d;
  logic        out_valid_q;
  slf_out_t    out_q, out_d;

  slf_fifo_ctrl_t  tx_ctrl, rx_ctrl;
  logic [31:0]     tx_head, rx_head, move_word;
  logic [LvlW-1:0] tx_level, tx_level_next, rx_level, rx_level_next;
  logic            accept, tdf_now, rdf_now, tdf_next, rdf_next;
  logic [2:0]      setup_idx;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign setup_idx  = 3'(in_data_i.reg_sel - RegCfgr0);

  assign tdf_now  = 8'(tx_level) <= 8'(fcr_q[1:0]);
  assign rdf_now  = 8'(rx_level) > 8'(fcr_q[17:16]);
  assign tdf_next = 8'(tx_level_next) <= 8'(fcr_d[1:0]);
  assign rdf_next = 8'(rx_level_next) > 8'(fcr_d[17:16]);

  assign move_word = (tx_level == '0) ? in_data_i.write_data : tx_head;

  always_comb begin
    cr_d     = cr_q;
    ier_d    = ier_q;
    der_d    = der_q;
    fcr_d    = fcr_q;
    tcr_d    = tcr_q;
    setup_d  = setup_q;
    sticky_d = sticky_q;
    tx_ctrl  = '0;
    rx_ctrl  = '0;
    out_d    = '0;
    if (accept) begin
      priority if (in_data_i.reg_sel > RegRdror) begin
        out_d.bad_offset = 1'b1;
      end else if (in_data_i.op) begin
        unique case (in_data_i.reg_sel)
          RegCr: begin
            cr_d = in_data_i.write_data;
            if (in_data_i.write_data[CrRstBit]) begin
              sticky_d      = '0;
              tx_ctrl.flush = 1'b1;
              rx_ctrl.flush = 1'b1;
            end
            if (in_data_i.write_data[CrRtfBit]) tx_ctrl.flush = 1'b1;
            if (in_data_i.write_data[CrRrfBit]) rx_ctrl.flush = 1'b1;
          end
          RegSr:  sticky_d = sticky_q & ~in_data_i.write_data[10:8];
          RegIer: ier_d = in_data_i.write_data;
          RegDer: der_d = in_data_i.write_data;
          RegCfgr0, RegCfgr1, RegDmr0, RegDmr1, RegCcr, RegCcr1: begin
            setup_d[setup_idx] = in_data_i.write_data;
          end
          RegFcr: fcr_d = in_data_i.write_data;
          RegTcr: tcr_d = in_data_i.write_data;
          RegTdr: begin
            if (tx_level < LvlW'(FIFO_DEPTH)) begin
              tx_ctrl.push = 1'b1;
              if (cr_q[CrEnBit] && (rx_level < LvlW'(FIFO_DEPTH))) begin
                tx_ctrl.pop  = 1'b1;
                rx_ctrl.push = 1'b1;
                sticky_d     = sticky_q | FlagWcf | FlagFcf;
                if (tx_level == '0) sticky_d = sticky_q | FlagWcf | FlagFcf | FlagTcf;
              end
            end
          end
          default: ;
        endcase
      end else begin
        unique case (in_data_i.reg_sel)
          RegVerid: out_d.read_data = VersionId;
          RegParam: out_d.read_data = ParamId;
          RegCr:    out_d.read_data = cr_q;
          RegSr:    out_d.read_data = {21'b0, sticky_q, 6'b0, rdf_now, tdf_now};
          RegIer:   out_d.read_data = ier_q;
          RegDer:   out_d.read_data = der_q;
          RegCfgr0, RegCfgr1, RegDmr0, RegDmr1, RegCcr, RegCcr1: begin
            out_d.read_data = setup_q[setup_idx];
          end
          RegFcr:   out_d.read_data = fcr_q;
          RegFsr:   out_d.read_data = (32'(rx_level) << 16) | 32'(tx_level);
          RegTcr:   out_d.read_data = tcr_q;
          RegRsr:   out_d.read_data = (rx_level == '0) ? RsrRxEmpty : '0;
          RegRdr: begin
            if (rx_level != '0) begin
              out_d.read_data = rx_head;
              rx_ctrl.pop     = 1'b1;
            end
          end
          RegRdror: if (rx_level != '0) out_d.read_data = rx_head;
          default: ;
        endcase
      end
    end
    out_d.irq = (ier_d[0] & tdf_next) | (ier_d[1] & rdf_next) |
                (|(ier_d[10:8] & sticky_d));
  end

  slf_fifo #(.Depth(FIFO_DEPTH)) u_tx_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (tx_ctrl),
    .push_data_i  (in_data_i.write_data),
    .head_o       (tx_head),
    .level_o      (tx_level),
    .level_next_o (tx_level_next)
  );

  slf_fifo #(.Depth(FIFO_DEPTH)) u_rx_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (rx_ctrl),
    .push_data_i  (move_word),
    .head_o       (rx_head),
    .level_o      (rx_level),
    .level_next_o (rx_level_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_q        <= '0;
      ier_q       <= '0;
      der_q       <= '0;
      fcr_q       <= '0;
      tcr_q       <= TcrReset;
      setup_q     <= '{default: '0};
      sticky_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cr_q     <= cr_d;
      ier_q    <= ier_d;
      der_q    <= der_d;
      fcr_q    <= fcr_d;
      tcr_q    <= tcr_d;
      setup_q  <= setup_d;
      sticky_q <= sticky_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SLF_ASSERT(a_level_bound, clk_i, rst_ni,
    (tx_level <= LvlW'(FIFO_DEPTH)) && (rx_level <= LvlW'(FIFO_DEPTH)),
    "FIFO level beyond depth")
  `SLF_ASSERT_NEXT(a_bad_no_effect, clk_i, rst_ni,
    accept && (in_data_i.reg_sel > RegRdror),
    $stable(cr_q) && $stable(tx_level) && $stable(rx_level) && $stable(sticky_q),
    "invalid access changed state")
  `SLF_ASSERT_NEXT(a_rdr_pops, clk_i, rst_ni,
    accept && !in_data_i.op && (in_data_i.reg_sel == RegRdr) && (rx_level != '0),
    rx_level == $past(rx_level) - LvlW'(1),
    "RDR read did not pop RX")
  `SLF_ASSERT_NEXT(a_no_move_when_off, clk_i, rst_ni,
    !cr_q[CrEnBit],
    rx_level <= $past(rx_level),
    "RX grew while module disabled")

endmodule

### dv/spi_loopback_fifo_registers_unit_test.sv
// Self-checking testbench for the loopback serial register block: directed and random bus words.
module spi_loopback_fifo_registers_unit_test import slf_pkg::*;;

  localparam int Depth = 4;
  localparam logic OpRead = 1'b0;
  localparam logic OpWrite = 1'b1;
  localparam logic [31:0] IrqMask = 32'h0000_0703;
  localparam logic [4:0] SelGap = RegRdror + 5'd1;
  localparam logic [4:0] SelTop = 5'd31;
  localparam int PhaseWords = 400;
  localparam int ReportMax = 10;

  typedef struct packed {
    slf_in_t  acc;
    logic     typed;
    slf_out_t want;
  } row_t;

  localparam int NumRows = 27;
  localparam row_t Script [NumRows] = '{
    '{'{OpRead,  RegVerid, 32'h0},         1'b1, '{VersionId, 1'b0, 1'b0}},
    '{'{OpRead,  RegParam, 32'h0},         1'b1, '{ParamId, 1'b0, 1'b0}},
    '{'{OpRead,  RegTcr,   32'h0},         1'b1, '{TcrReset, 1'b0, 1'b0}},
    '{'{OpRead,  RegRsr,   32'h0},         1'b1, '{RsrRxEmpty, 1'b0, 1'b0}},
    '{'{OpRead,  RegFsr,   32'h0},         1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{OpRead,  SelTop,   32'h0},         1'b1, '{32'h0, 1'b0, 1'b1}},
    '{'{OpWrite, SelGap,   32'hFFFF_FFFF}, 1'b1, '{32'h0, 1'b0, 1'b1}},
    '{'{OpRead,  RegRdr,   32'h0},         1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{OpRead,  RegTdr,   32'h0},         1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{OpWrite, RegVerid, 32'hFFFF_FFFF}, 1'b1, '{32'h0, 1'b0, 1'b0}},
    '{'{OpRead,  RegVerid, 32'h0},         1'b1, '{VersionId, 1'b0, 1'b0}},
    '{'{OpWrite, RegIer,   32'hFFFF_FFFF}, 1'b0, '0},
    '{'{OpWrite, RegCr,    32'h0000_0001}, 1'b0, '0},
    '{'{OpWrite, RegTdr,   32'hFFFF_FFFF}, 1'b0, '0},
    '{'{OpRead,  RegSr,    32'h0},         1'b0, '0},
    '{'{OpRead,  RegRdror, 32'h0},         1'b0, '0},
    '{'{OpRead,  RegRdr,   32'h0},         1'b0, '0},
    '{'{OpWrite, RegSr,    32'hFFFF_FFFF}, 1'b0, '0},
    '{'{OpWrite, RegCr,    32'h0000_0000}, 1'b0, '0},
    '{'{OpWrite, RegTdr,   32'h0000_0000}, 1'b0, '0},
    '{'{OpWrite, RegTdr,   32'h5555_5555}, 1'b0, '0},
    '{'{OpWrite, RegTdr,   32'hAAAA_AAAA}, 1'b0, '0},
    '{'{OpWrite, RegTdr,   32'h1234_5678}, 1'b0, '0},
    '{'{OpWrite, RegTdr,   32'hDEAD_BEEF}, 1'b0, '0},
    '{'{OpWrite, RegFcr,   32'h0003_0003}, 1'b0, '0},
    '{'{OpRead,  RegFsr,   32'h0},         1'b0, '0},
    '{'{OpWrite, RegCr,    32'h0000_0303}, 1'b0, '0}
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  slf_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  slf_out_t out_data;
  logic     word_typed = 1'b0;
  slf_out_t word_want = '0;

  int src_idle = 27;
  int sink_idle = 67;
  int sent = 0;
  int checked = 0;
  int moves = 0;
  int drops = 0;
  int pops = 0;
  int errors = 0;

  slf_out_t pending_results [$];

  logic [31:0] cr_q = '0;
  logic [31:0] ier_q = '0;
  logic [31:0] der_q = '0;
  logic [31:0] fcr_q = '0;
  logic [31:0] tcr_q = TcrReset;
  logic [31:0] setup_q [NumSetup] = '{default: '0};
  logic [2:0]  flags_q = '0;
  logic [31:0] tx_mem [Depth];
  logic [31:0] rx_mem [Depth];
  logic [1:0]  tx_rd = '0, tx_wr = '0, rx_rd = '0, rx_wr = '0;
  logic [2:0]  tx_cnt = '0, rx_cnt = '0;

  spi_loopback_fifo_registers_unit #(.FIFO_DEPTH(Depth)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] status_now();
    return {21'b0, flags_q, 6'b0, rx_cnt > {1'b0, fcr_q[17:16]}, tx_cnt <= {1'b0, fcr_q[1:0]}};
  endfunction

  function automatic slf_out_t predict_access(input slf_in_t a);
    slf_out_t r;
    r = '0;
    if (a.reg_sel > RegRdror) begin
      r.bad_offset = 1'b1;
    end else if (a.op == OpWrite) begin
      case (a.reg_sel)
        RegCr: begin
          cr_q = a.write_data;
          if (a.write_data[CrRstBit]) begin
            flags_q = '0;
            tx_rd = '0; tx_wr = '0; tx_cnt = '0;
            rx_rd = '0; rx_wr = '0; rx_cnt = '0;
          end
          if (a.write_data[CrRtfBit]) begin
            tx_rd = '0; tx_wr = '0; tx_cnt = '0;
          end
          if (a.write_data[CrRrfBit]) begin
            rx_rd = '0; rx_wr = '0; rx_cnt = '0;
          end
        end
        RegSr: flags_q = flags_q & ~a.write_data[10:8];
        RegIer: ier_q = a.write_data;
        RegDer: der_q = a.write_data;
        RegCfgr0, RegCfgr1, RegDmr0, RegDmr1, RegCcr, RegCcr1:
          setup_q[3'(a.reg_sel - RegCfgr0)] = a.write_data;
        RegFcr: fcr_q = a.write_data;
        RegTcr: tcr_q = a.write_data;
        RegTdr: begin
          if (tx_cnt < Depth) begin
            tx_mem[tx_wr] = a.write_data;
            tx_wr++;
            tx_cnt++;
            if (cr_q[CrEnBit] && rx_cnt < Depth) begin
              rx_mem[rx_wr] = tx_mem[tx_rd];
              tx_rd++;
              tx_cnt--;
              rx_wr++;
              rx_cnt++;
              flags_q = flags_q | FlagWcf | FlagFcf;
              if (tx_cnt == 0) flags_q = flags_q | FlagTcf;
              moves++;
            end
          end else begin
            drops++;
          end
        end
        default: ;
      endcase
    end else begin
      case (a.reg_sel)
        RegVerid: r.read_data = VersionId;
        RegParam: r.read_data = ParamId;
        RegCr: r.read_data = cr_q;
        RegSr: r.read_data = status_now();
        RegIer: r.read_data = ier_q;
        RegDer: r.read_data = der_q;
        RegCfgr0, RegCfgr1, RegDmr0, RegDmr1, RegCcr, RegCcr1:
          r.read_data = setup_q[3'(a.reg_sel - RegCfgr0)];
        RegFcr: r.read_data = fcr_q;
        RegFsr: r.read_data = {13'b0, rx_cnt, 13'b0, tx_cnt};
        RegTcr: r.read_data = tcr_q;
        RegRsr: r.read_data = (rx_cnt == 0) ? RsrRxEmpty : 32'h0;
        RegRdr: begin
          if (rx_cnt != 0) begin
            r.read_data = rx_mem[rx_rd];
            rx_rd++;
            rx_cnt--;
            pops++;
          end
        end
        RegRdror: if (rx_cnt != 0) r.read_data = rx_mem[rx_rd];
        default: ;
      endcase
    end
    r.irq = |(status_now() & ier_q & IrqMask);
    return r;
  endfunction

  // TDR pushes and RDR pops weighted highest, CR writes that mostly enable the module, plus noise
  function automatic slf_in_t rand_access();
    slf_in_t a;
    int unsigned pick;
    pick = $urandom_range(99);
    a.op = OpWrite;
    a.write_data = $urandom;
    a.reg_sel = RegTdr;
    if (pick < 28) begin
      a.reg_sel = RegTdr;
    end else if (pick < 46) begin
      a.op = OpRead;
      a.reg_sel = RegRdr;
    end else if (pick < 52) begin
      a.op = OpRead;
      a.reg_sel = RegRdror;
    end else if (pick < 58) begin
      a.reg_sel = RegCr;
      if ($urandom_range(3) != 0) begin
        a.write_data[CrEnBit] = 1'b1;
        a.write_data[CrRstBit] = 1'b0;
        a.write_data[CrRtfBit] = 1'b0;
        a.write_data[CrRrfBit] = 1'b0;
      end
    end else if (pick < 63) begin
      a.reg_sel = RegSr;
    end else if (pick < 67) begin
      a.reg_sel = RegIer;
    end else if (pick < 71) begin
      a.reg_sel = RegFcr;
    end else if (pick < 80) begin
      a.op = OpRead;
      a.reg_sel = 5'($urandom_range(RegRdror));
    end else if (pick < 88) begin
      a.reg_sel = 5'($urandom_range(RegRdror));
    end else begin
      a.op = 1'($urandom_range(1));
      a.reg_sel = 5'($urandom_range(SelTop));
    end
    return a;
  endfunction

  task automatic present(input slf_in_t w, input logic typed, input slf_out_t want);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    word_typed <= typed;
    word_want <= want;
    sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(99) >= sink_idle);

  always @(posedge clk) begin : monitor
    slf_out_t want;
    slf_out_t model;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= ReportMax) $display("unexpected result word %h", out_data);
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (out_data.read_data !== want.read_data || out_data.irq !== want.irq ||
              out_data.bad_offset !== want.bad_offset) begin
            errors++;
            if (errors <= ReportMax)
              $display("mismatch: read_data %h/%h irq %b/%b bad_offset %b/%b (exp/act)",
                       want.read_data, out_data.read_data, want.irq, out_data.irq,
                       want.bad_offset, out_data.bad_offset);
          end
        end
      end
      if (in_valid && in_ready) begin
        model = predict_access(in_data);
        pending_results.push_back(word_typed ? word_want : model);
      end
    end
  end

  initial begin : stimulus
    slf_in_t w;
    int live;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (Script[i]) present(Script[i].acc, Script[i].typed, Script[i].want);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle = 27; sink_idle = 67; end
        1: begin src_idle = 67; sink_idle = 27; end
        default: begin src_idle = 0; sink_idle = 0; end
      endcase
      live = 0;
      while (live < PhaseWords) begin
        w = rand_access();
        present(w, 1'b0, '0);
        if (w.reg_sel <= RegRdror) live++;
      end
      // hold off until every outstanding word has drained
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_results.size() != 0) @(posedge clk);
    end
    repeat (20) @(posedge clk);
    $display("covered %0d bus words, %0d results checked, %0d TX->RX moves,",
             sent, checked, moves);
    $display("%0d TDR drops, %0d RX pops, %0d mismatches", drops, pops, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("spi_loopback_fifo_registers_unit_test: PASS");
    end else begin
      $display("spi_loopback_fifo_registers_unit_test: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(8 * 200000);
    $display("spi_loopback_fifo_registers_unit_test: FAIL");
    $finish;
  end

endmodule
